// ===== sv/sha256_stream_hasher_core_assert.svh =====
// Assertion macros for the SHA-256 stream hasher.
// Clocked on clk, disabled while rst_n is low; empty bodies under SYNTHESIS.
`ifndef SHA256_STREAM_HASHER_CORE_ASSERT_SVH
`define SHA256_STREAM_HASHER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SHS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    `SHS_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define SHS_ASSERT(lbl, prop, msg)
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/shs_pkg.sv =====
// Shared constants and types for the SHA-256 stream hasher.
// No dependencies; used by all modules of the block except shs_blk_ram.
`default_nettype none

package shs_pkg;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int unsigned LEN_POS = 56;

    localparam logic [31:0] HASH_IV [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Datapath controls from the sequencer to the round unit
    typedef struct packed {
        logic load_en;    // shift a hash word into the working vars
        logic sched_en;   // produce next schedule word and W+K
        logic sched_mem;  // schedule word comes from the block buffer
        logic round_en;   // run one compression round
        logic add_shift;  // rotate working vars during the final add
    } shs_rnd_ctl_t;

endpackage

`default_nettype wire

// ===== sv/shs_blk_ram.sv =====
// 64-byte block buffer: 16 x 32-bit synchronous RAM with byte-lane writes.
// Byte 0 of each word sits in the top lane (big-endian). Standalone.
`default_nettype none

module shs_blk_ram (
    input  wire logic        clk,
    input  wire logic        wr_en,
    input  wire logic [5:0]  wr_addr,
    input  wire logic [7:0]  wr_byte,
    input  wire logic        rd_en,
    input  wire logic [3:0]  rd_addr,
    output logic      [31:0] rd_data
);

    logic [31:0] mem_reg [16];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/shs_hash_ram.sv =====
// Eight-word hash state RAM, one read and one write port, registered read.
// Unwritten entries read as the initial hash values; uses shs_pkg.
`default_nettype none

module shs_hash_ram (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        clear,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_addr,
    input  wire logic [31:0] wr_data,
    input  wire logic        rd_en,
    input  wire logic [2:0]  rd_addr,
    output logic      [31:0] rd_data
);
    import shs_pkg::*;

    logic [31:0] mem_reg [8];
    logic [7:0]  valid_reg;
    logic        rd_valid_reg;
    logic [2:0]  rd_addr_reg;
    logic [31:0] rd_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem_reg[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : HASH_IV[rd_addr_reg];

endmodule

`default_nettype wire

// ===== sv/shs_round.sv =====
// SHA-256 round unit: working vars a..h, 16-word schedule window, W+K register.
// Driven by shs_pkg::shs_rnd_ctl_t from the sequencer; uses shs_pkg.
`default_nettype none

module shs_round (
    input  wire logic                 clk,
    input  wire shs_pkg::shs_rnd_ctl_t ctl,
    input  wire logic [5:0]           k_idx,
    input  wire logic [31:0]          load_word,
    input  wire logic [31:0]          blk_word,
    output logic      [31:0]          var_a
);
    import shs_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] var_reg  [8];
    logic [31:0] var_next [8];
    logic [31:0] w_reg    [16];
    logic [31:0] w_next   [16];
    logic [31:0] wk_reg;
    logic [31:0] wk_next;

    logic [31:0] s1, ch, t1, s0, maj, t2, g0, g1, w_new;

    always_comb
    begin
        s1  = rotr(var_reg[4], 6) ^ rotr(var_reg[4], 11) ^ rotr(var_reg[4], 25);
        ch  = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        t1  = var_reg[7] + s1 + ch + wk_reg;
        s0  = rotr(var_reg[0], 2) ^ rotr(var_reg[0], 13) ^ rotr(var_reg[0], 22);
        maj = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
            ^ (var_reg[1] & var_reg[2]);
        t2  = s0 + maj;

        // window: w_reg[0] = W[s-16], w_reg[1] = W[s-15], w_reg[9] = W[s-7], w_reg[14] = W[s-2]
        g0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        g1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = ctl.sched_mem ? blk_word : (w_reg[0] + g0 + w_reg[9] + g1);

        var_next = var_reg;
        w_next   = w_reg;
        wk_next  = wk_reg;

        if (ctl.load_en)
        begin
            var_next[0] = load_word;
            for (int i = 1; i < 8; i++)
            begin
                var_next[i] = var_reg[i-1];
            end
        end
        else if (ctl.round_en)
        begin
            var_next[0] = t1 + t2;
            var_next[1] = var_reg[0];
            var_next[2] = var_reg[1];
            var_next[3] = var_reg[2];
            var_next[4] = var_reg[3] + t1;
            var_next[5] = var_reg[4];
            var_next[6] = var_reg[5];
            var_next[7] = var_reg[6];
        end
        else if (ctl.add_shift)
        begin
            for (int i = 0; i < 7; i++)
            begin
                var_next[i] = var_reg[i+1];
            end
            var_next[7] = var_reg[0];
        end

        if (ctl.sched_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i+1];
            end
            w_next[15] = w_new;
            wk_next    = w_new + ROUND_K[k_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        var_reg <= var_next;
        w_reg   <= w_next;
        wk_reg  <= wk_next;
    end

    assign var_a = var_reg[0];

endmodule

`default_nettype wire

// ===== sv/sha256_stream_hasher_core.sv =====
// SHA-256 over a byte stream. A plain byte is written to the block buffer; the byte that
// fills a block adds a compression (load the hash words, the round steps, then the
// read-add-write of the hash RAM), during which in_stall holds off the input.
// A last word adds one byte write per pad position up to the block end, one or
// two compressions; the 8 digest words leave during the final add, one per hash RAM
// read-add step, which waits while out_stall is high. Reset (async, rst_n low) clears control.
`default_nettype none

module sha256_stream_hasher_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        has_byte,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [31:0] digest_word,
    output logic      [2:0]  word_index,
    output logic             last_word
);
    import shs_pkg::*;

`include "sha256_stream_hasher_core_assert.svh"

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PAD    = 3'd1;
    localparam logic [2:0] ST_LOAD   = 3'd2;
    localparam logic [2:0] ST_ROUND  = 3'd3;
    localparam logic [2:0] ST_ADD_RD = 3'd4;
    localparam logic [2:0] ST_ADD_WR = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic        pad_pend_reg, pad_pend_next;
    logic        pad_first_reg, pad_first_next;
    logic        len_ok_reg, len_ok_next;
    logic        final_reg, final_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_word_reg, out_word_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        out_last_reg, out_last_next;

    logic        in_acc;
    logic        out_free;
    logic        len_cur;
    logic        blk_we;
    logic [7:0]  blk_wbyte;
    logic        blk_re;
    logic [3:0]  blk_raddr;
    logic [31:0] blk_rdata;
    logic        h_re;
    logic [2:0]  h_raddr;
    logic        h_we;
    logic        h_clear;
    logic [31:0] h_rdata;
    logic [31:0] var_a;
    logic [31:0] sum;
    shs_rnd_ctl_t rctl;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign sum      = h_rdata + var_a;
    // length field goes in this block if the pad byte landed before LEN_POS
    assign len_cur  = len_ok_reg || (pad_first_reg && (fill_reg < 6'(LEN_POS)));

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        fill_next      = fill_reg;
        bits_next      = bits_reg;
        pad_pend_next  = pad_pend_reg;
        pad_first_next = pad_first_reg;
        len_ok_next    = len_ok_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        blk_we         = 1'b0;
        blk_wbyte      = data_byte;
        blk_re         = 1'b0;
        blk_raddr      = 4'd0;
        h_re           = 1'b0;
        h_raddr        = 3'd0;
        h_we           = 1'b0;
        h_clear        = 1'b0;
        rctl           = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (has_byte)
                    begin
                        blk_we    = 1'b1;
                        bits_next = bits_reg + 64'd8;
                        fill_next = fill_reg + 6'd1;
                    end
                    if (has_byte && (fill_reg == 6'd63))
                    begin
                        state_next     = ST_LOAD;
                        cnt_next       = 7'd0;
                        pad_pend_next  = last;
                        pad_first_next = 1'b1;
                        len_ok_next    = 1'b0;
                        final_next     = 1'b0;
                    end
                    else if (last)
                    begin
                        state_next     = ST_PAD;
                        pad_first_next = 1'b1;
                        len_ok_next    = 1'b0;
                    end
                end
            end
            ST_PAD:
            begin
                blk_we = 1'b1;
                if (pad_first_reg)
                begin
                    blk_wbyte = PAD_BYTE;
                end
                else if (len_ok_reg && (fill_reg >= 6'(LEN_POS)))
                begin
                    // big-endian bit count: byte 63 holds bits 7:0
                    blk_wbyte = bits_reg[{~fill_reg[2:0], 3'b000} +: 8];
                end
                else
                begin
                    blk_wbyte = 8'd0;
                end
                fill_next      = fill_reg + 6'd1;
                pad_first_next = 1'b0;
                len_ok_next    = len_cur;
                if (fill_reg == 6'd63)
                begin
                    state_next    = ST_LOAD;
                    cnt_next      = 7'd0;
                    final_next    = len_cur;
                    pad_pend_next = 1'b1;
                    len_ok_next   = 1'b1;
                end
            end
            ST_LOAD:
            begin
                // hash words read 7 down to 0, shifted in at a
                if (cnt_reg < 7'd8)
                begin
                    h_re    = 1'b1;
                    h_raddr = ~cnt_reg[2:0];
                end
                if (cnt_reg != 7'd0)
                begin
                    rctl.load_en = 1'b1;
                end
                if (cnt_reg == 7'd8)
                begin
                    blk_re     = 1'b1;
                    blk_raddr  = 4'd0;
                    state_next = ST_ROUND;
                    cnt_next   = 7'd0;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_ROUND:
            begin
                // schedule runs one step ahead of the rounds
                rctl.sched_en  = (cnt_reg < 7'd64);
                rctl.sched_mem = (cnt_reg < 7'd16);
                rctl.round_en  = (cnt_reg != 7'd0);
                if (cnt_reg < 7'd15)
                begin
                    blk_re    = 1'b1;
                    blk_raddr = cnt_reg[3:0] + 4'd1;
                end
                if (cnt_reg == 7'd64)
                begin
                    state_next = ST_ADD_RD;
                    cnt_next   = 7'd0;
                end
                else
                begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_ADD_RD:
            begin
                h_re       = 1'b1;
                h_raddr    = cnt_reg[2:0];
                state_next = ST_ADD_WR;
            end
            ST_ADD_WR:
            begin
                if (!final_reg || out_free)
                begin
                    rctl.add_shift = 1'b1;
                    if (final_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_word_next  = sum;
                        out_idx_next   = cnt_reg[2:0];
                        out_last_next  = (cnt_reg[2:0] == 3'd7);
                    end
                    else
                    begin
                        h_we = 1'b1;
                    end
                    if (cnt_reg[2:0] == 3'd7)
                    begin
                        if (final_reg)
                        begin
                            h_clear        = 1'b1;
                            bits_next      = 64'd0;
                            fill_next      = 6'd0;
                            pad_pend_next  = 1'b0;
                            pad_first_next = 1'b0;
                            len_ok_next    = 1'b0;
                            final_next     = 1'b0;
                            state_next     = ST_IDLE;
                        end
                        else if (pad_pend_reg)
                        begin
                            state_next = ST_PAD;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 7'd1;
                        state_next = ST_ADD_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            fill_reg      <= '0;
            bits_reg      <= '0;
            pad_pend_reg  <= 1'b0;
            pad_first_reg <= 1'b0;
            len_ok_reg    <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fill_reg      <= fill_next;
            bits_reg      <= bits_next;
            pad_pend_reg  <= pad_pend_next;
            pad_first_reg <= pad_first_next;
            len_ok_reg    <= len_ok_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

    shs_blk_ram u_blk_ram (
        .clk     (clk),
        .wr_en   (blk_we),
        .wr_addr (fill_reg),
        .wr_byte (blk_wbyte),
        .rd_en   (blk_re),
        .rd_addr (blk_raddr),
        .rd_data (blk_rdata)
    );

    shs_hash_ram u_hash_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (h_clear),
        .wr_en   (h_we),
        .wr_addr (cnt_reg[2:0]),
        .wr_data (sum),
        .rd_en   (h_re),
        .rd_addr (h_raddr),
        .rd_data (h_rdata)
    );

    shs_round u_round (
        .clk       (clk),
        .ctl       (rctl),
        .k_idx     (cnt_reg[5:0]),
        .load_word (h_rdata),
        .blk_word  (blk_rdata),
        .var_a     (var_a)
    );

    assign out_valid   = out_valid_reg;
    assign digest_word = out_word_reg;
    assign word_index  = out_idx_reg;
    assign last_word   = out_last_reg;

    `SHS_ASSERT(a_round_cnt_bound, (state_reg == ST_ROUND) |-> (cnt_reg <= 7'd64), "round counter overran")
    `SHS_ASSERT(a_load_block_full, (state_reg == ST_LOAD) |-> (fill_reg == 6'd0), "compress started on a partial block")
    `SHS_ASSERT(a_out_from_add, $rose(out_valid_reg) |-> ($past(state_reg) == ST_ADD_WR), "digest word not from final add")
    `SHS_ASSERT_NEXT(a_clear_after_digest, (state_reg == ST_ADD_WR) && final_reg && out_free && (cnt_reg[2:0] == 3'd7), (state_reg == ST_IDLE) && (bits_reg == 64'd0) && !final_reg, "state not cleared after digest")

endmodule

`default_nettype wire
